@@ rtl/core/wheel_speed_tachometer_macros.svh @@
// ----------------------------------------------------------------------------
// wheel speed tachometer assertion macros
// shared property wrappers used by the port checker
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_TACHOMETER_MACROS_SVH
`define WHEEL_SPEED_TACHOMETER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define WST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wst same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define WST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wst next-cycle check failed");

`endif

@@ rtl/core/wst_pkg.sv @@
// ----------------------------------------------------------------------------
// wst_pkg
// types and constants of the wheel speed tachometer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wst_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } wst_state_t;

  // configuration register indexes
  localparam logic [7:0] REG_ENABLE  = 8'd0;
  localparam logic [7:0] REG_LOCKOUT = 8'd1;
  localparam logic [7:0] REG_STOP    = 8'd2;
  localparam logic [7:0] REG_SCALE   = 8'd3;

  // field widths
  localparam int unsigned RPM_W     = 16;
  localparam int unsigned SPEED_W   = 24;
  localparam int unsigned LOCKOUT_W = 16;
  localparam int unsigned STOP_W    = 20;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // reset values of the configuration registers
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST = 16'd150;
  localparam logic [STOP_W-1:0]    STOP_RST    = 20'd2500;
  localparam logic [SCALE_W-1:0]   SCALE_RST   = 16'd8160;

  // rpm saturation limit
  localparam logic [31:0] RPM_LIMIT = 32'h0000_FFFF;

endpackage

@@ rtl/core/wheel_speed_tachometer.sv @@
// ----------------------------------------------------------------------------
// wheel_speed_tachometer
// pulse period tachometer: rpm and speed from millisecond ticks
// ----------------------------------------------------------------------------
// Usage: feed one word per millisecond tick on the in_ channel, in_tdata[0]
// set when a sensor pulse arrived during that tick. Each accepted word gives
// exactly one result word on the out_ channel: rpm, speed in 1/256 km/h,
// stopped flag and pulse accepted flag. Registers (enable, lockout, stop
// threshold, speed scale) are written on the cfg_ channel, always ready;
// write them only while no tick is in flight; the block does not enforce it.
// A tick that recomputes rpm runs the restoring divider one quotient bit
// per cycle in ST_DIV, then ST_MUL forms rpm and speed, and ST_FIN loads
// the output register; a new tick is taken only after that. A tick without
// recompute goes from accept straight to ST_FIN.
// in_tready is low while a tick is being worked on.
// Reset clears the count, rpm and speed, sets the stored interval to 150
// and loads the register defaults (disabled). When the receiver stalls the
// result holds in the output register; the next tick is still accepted and
// worked, and only waits to load its result until the register is free.
`timescale 1ns / 1ps

module wheel_speed_tachometer #(
  parameter int unsigned COUNT_BITS    = 20,
  parameter int unsigned RPM_NUMERATOR = 60000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [0] pulse, [7:1] zero
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wst_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: [15:0] rpm_out, [39:16] speed_q8, [40] stopped,
  // [41] pulse_accepted, [47:42] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wst_pkg::OUT_DATA_W-1:0]     out_tdata,
  // register write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wst_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import wst_pkg::*;

  localparam int unsigned NUM_W  = $clog2(RPM_NUMERATOR + 1);
  localparam int unsigned STEP_W = $clog2(NUM_W);
  localparam int unsigned CMP_W  = (COUNT_BITS > STOP_W) ? COUNT_BITS : STOP_W;
  localparam logic [NUM_W-1:0]      NUM_VAL   = NUM_W'(RPM_NUMERATOR);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] LAST_RST  = COUNT_BITS'(150);

  // configuration registers
  logic                 en_r;
  logic [LOCKOUT_W-1:0] lockout_r;
  logic [STOP_W-1:0]    stop_ticks_r;
  logic [SCALE_W-1:0]   scale_r;

  // sequencer and datapath registers
  wst_state_t              state_r, state_nxt;
  logic [COUNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0]   last_r, last_nxt;
  logic [COUNT_BITS-1:0]   div_r, div_nxt;
  logic [COUNT_BITS:0]     rem_r, rem_nxt;
  logic [NUM_W-1:0]        quo_r, quo_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [RPM_W-1:0]        rpm_r, rpm_nxt;
  logic [SPEED_W-1:0]      speed_r, speed_nxt;
  logic                    stop_r, stop_nxt;
  logic                    acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  // combinational helpers
  logic                    in_fire;
  logic                    pulse;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic [CMP_W-1:0]        cnt_inc_w;
  logic                    pass_lockout;
  logic                    decay;
  logic [COUNT_BITS:0]     rem_shift;
  logic                    rem_ge;
  logic [31:0]             quo_w;
  logic [RPM_W-1:0]        rpm_sat;
  logic [31:0]             prod;
  logic                    out_free;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r         <= 1'b0;
      lockout_r    <= LOCKOUT_RST;
      stop_ticks_r <= STOP_RST;
      scale_r      <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:  en_r         <= cfg_data[0];
        REG_LOCKOUT: lockout_r    <= cfg_data[LOCKOUT_W-1:0];
        REG_STOP:    stop_ticks_r <= cfg_data[STOP_W-1:0];
        REG_SCALE:   scale_r      <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // tick front end: saturating count and the two recompute conditions
  assign in_fire      = in_tvalid && in_tready;
  assign pulse        = in_tdata[0];
  assign cnt_inc      = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign cnt_inc_w    = CMP_W'(cnt_inc);
  assign pass_lockout = pulse && (cnt_inc_w > CMP_W'(lockout_r));
  assign decay        = cnt_inc > last_r;

  // one restoring division step
  assign rem_shift = {rem_r[COUNT_BITS-1:0], quo_r[NUM_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_r};

  // rpm saturation and speed product
  assign quo_w   = 32'(quo_r);
  assign rpm_sat = (quo_w > RPM_LIMIT) ? RPM_W'(RPM_LIMIT) : quo_w[RPM_W-1:0];
  assign prod    = 32'(rpm_sat) * 32'(scale_r);

  assign out_free = !out_valid_r || out_tready;

  // sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    rpm_nxt       = rpm_r;
    speed_nxt     = speed_r;
    stop_nxt      = stop_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // result word leaves
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (en_r) begin
            acc_nxt  = pass_lockout;
            cnt_nxt  = pass_lockout ? '0 : cnt_inc;
            last_nxt = pass_lockout ? cnt_inc : last_r;
            stop_nxt = !pass_lockout && (cnt_inc_w > CMP_W'(stop_ticks_r));
            div_nxt  = cnt_inc;
            rem_nxt  = '0;
            quo_nxt  = NUM_VAL;
            step_nxt = STEP_W'(NUM_W - 1);
            if ((decay || pass_lockout) && (cnt_inc != '0)) begin
              state_nxt = ST_DIV;
            end else begin
              state_nxt = ST_FIN;
            end
          end else begin
            acc_nxt   = 1'b0;
            stop_nxt  = CMP_W'(cnt_r) > CMP_W'(stop_ticks_r);
            state_nxt = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = rem_ge ? (rem_shift - {1'b0, div_r}) : rem_shift;
        quo_nxt  = {quo_r[NUM_W-2:0], rem_ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        rpm_nxt   = rpm_sat;
        speed_nxt = prod[31:8];
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, acc_r, stop_r, speed_r, rpm_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      last_r      <= LAST_RST;
      rpm_r       <= '0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      rpm_r       <= rpm_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    stop_r     <= stop_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/core/wst_checker.sv @@
// ----------------------------------------------------------------------------
// wst_checker
// port-level checks of the wheel speed tachometer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wheel_speed_tachometer_macros.svh"

module wst_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [wst_pkg::OUT_DATA_W-1:0]    out_tdata
);

  // a stalled result word holds
  `WST_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // one tick at a time: ready drops after an accept
  `WST_ASSERT_NEXT(a_one_tick, in_tvalid && in_tready, !in_tready)

  // an accepted pulse clears the count, so never stopped on the same word
  `WST_ASSERT_IMP(a_acc_not_stopped, out_tvalid, !(out_tdata[41] && out_tdata[40]))

  // zero rpm always gives zero speed
  `WST_ASSERT_IMP(a_zero_speed, out_tvalid && (out_tdata[15:0] == 16'd0),
    out_tdata[39:16] == 24'd0)

endmodule

bind wheel_speed_tachometer wst_checker u_wst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
